// ===== rtl/cbpc_pkg.sv =====
// Shared types, constants and helpers of the constrained ballot path counter.
`timescale 1ns / 1ps
`default_nettype none

package cbpc_pkg;

    localparam int COUNT_W    = 30;
    localparam int GRID_W     = 11;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef logic [COUNT_W-1:0] t_count;

    localparam t_count COUNT_MOD = t_count'(998244353);

    // Register index, taken from paddr[2].
    localparam logic REG_GRID_SIZE = 1'b0;

    // Per-item control that the sequencer broadcasts to every cell.
    typedef struct packed {
        logic step;       // an item is accepted in this cycle
        logic last_item;  // the item closes the sweep
        logic skip_l;     // value is in the second list: no l step
        logic skip_r;     // value is in the first list: no r step
        logic shift;      // move the result chain one cell toward cell 0
    } t_cell_ctl;

    // Sum of two residues, reduced once.
    function automatic t_count mod_add(input t_count a, input t_count b);
        logic [COUNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, COUNT_MOD}) begin
            sum = sum - {1'b0, COUNT_MOD};
        end
        return sum[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cbpc_in_if.sv =====
// Input channel of the path counter: two list flags per word.
`timescale 1ns / 1ps
`default_nettype none

interface cbpc_in_if;
    logic valid;
    logic ready;
    logic value_in_first_list;
    logic value_in_second_list;

    modport source (output valid, output value_in_first_list,
                    output value_in_second_list, input ready);
    modport sink (input valid, input value_in_first_list,
                  input value_in_second_list, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbpc_out_if.sv =====
// Output channel of the path counter: one count per word.
`timescale 1ns / 1ps
`default_nettype none

interface cbpc_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] path_count;

    modport source (output valid, output path_count, input ready);
    modport sink (input valid, input path_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbpc_cell.sv =====
// One cell of the diagonal chain: the count at row index IDX and one result slot.
`timescale 1ns / 1ps
`default_nettype none

module cbpc_cell
    import cbpc_pkg::*;
#(
    parameter int IDX = 0,
    parameter int EW  = 12
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  wire  [EW-1:0]   i_v,
    input  wire  [EW-1:0]   i_n,
    input  t_count          i_prev_count,
    input  t_count          i_next_out,
    output t_count          o_count,
    output t_count          o_out
);

    localparam t_count ORIGIN = (IDX == 0) ? t_count'(1) : '0;

    t_count        r_count;
    t_count        r_out;
    logic [EW:0]   w_v;
    logic [EW:0]   w_lim;
    logic          w_on_diag;
    logic          w_take_l;
    logic          w_take_r;
    t_count        w_new;

    // The point (v - IDX, IDX) lies on the grid when 2*IDX <= v and v - IDX <= n.
    assign w_v       = {1'b0, i_v};
    assign w_lim     = {1'b0, i_n} + (EW+1)'(IDX);
    assign w_on_diag = ((EW+1)'(2 * IDX) <= w_v) && (w_v <= w_lim);
    assign w_take_l  = w_on_diag && ((EW+1)'(2 * IDX) < w_v) && !i_ctl.skip_l;
    assign w_take_r  = w_on_diag && (IDX != 0) && !i_ctl.skip_r;
    assign w_new     = mod_add(w_take_l ? r_count : '0, w_take_r ? i_prev_count : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= ORIGIN;
        end else if (i_ctl.step) begin
            r_count <= i_ctl.last_item ? ORIGIN : w_new;
        end
    end

    // The result chain: the cell at index n takes the final count, then it walks down.
    always_ff @(posedge i_clk) begin
        if (i_ctl.step && i_ctl.last_item) begin
            r_out <= (i_n == EW'(IDX)) ? w_new : '0;
        end else if (i_ctl.shift) begin
            r_out <= i_next_out;
        end
    end

    assign o_count = r_count;
    assign o_out   = r_out;

endmodule

`default_nettype wire

// ===== rtl/constrained_ballot_path_count.sv =====
// Top level of the constrained ballot path counter: sequencer, APB register and cell chain.
`timescale 1ns / 1ps
`default_nettype none

// Counts two-row tableau fillings (ballot paths) modulo 998244353. The block takes one
// input word per value v = 1..2n, in increasing order, each carrying two flags that say
// whether v is in the first or the second list. A chain of MAX_N+1 identical cells holds
// the path counts on the current anti-diagonal, one count per cell; every cell adds its
// own count and its lower neighbor's count in the same cycle, so the whole diagonal moves
// forward by one value per clock and the block takes one word per cycle unless a closing
// word waits as described below. After the word for value 2n the block clears the counts
// back to the origin at once and drops the count at (n, n) into a second chain of result
// slots, which carries it down toward cell 0 by one cell per clock and then into the
// output register once the output is free. A word that closes a sweep waits while the
// previous result is still in that chain. With n = 1 this stalls every sweep even when
// the output is ready; for larger n it happens only while a stalled output holds the
// previous result. All counts live in flip-flops that the synchronous reset sets directly,
// so there is no clearing pass.
// The grid size n is written through the APB port at byte address 0; 0 acts as 1, and
// values above MAX_N act as MAX_N. Write it only while no result is outstanding.
module constrained_ballot_path_count
    import cbpc_pkg::*;
#(
    parameter int MAX_N = 1024
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    cbpc_in_if.sink                i_in,
    cbpc_out_if.source             o_out,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [APB_ADDR_W-1:0]   paddr,
    input  wire [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int CW = $clog2(2 * MAX_N + 1);
    localparam int EW = (CW > GRID_W) ? CW : GRID_W;

    logic [GRID_W-1:0] r_grid;
    logic [EW-1:0]     r_vcnt;
    logic              r_busy;
    logic [EW-1:0]     r_fly;
    logic              r_out_valid;
    t_count            r_out_count;

    logic [EW-1:0]     w_grid;
    logic [EW-1:0]     w_n;
    logic [EW-1:0]     w_v;
    logic              w_last;
    logic              w_in_ready;
    logic              w_accept;
    logic              w_out_free;
    logic              w_shift;
    logic              w_load;
    logic              w_wr;
    t_cell_ctl         w_ctl;

    t_count            w_count [0:MAX_N];
    t_count            w_out   [0:MAX_N];
    t_count            w_prev  [0:MAX_N];
    t_count            w_next  [0:MAX_N];

    // Configuration register. Only the low eleven bits of the write data are kept.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= GRID_W'(1);
        end else if (w_wr && (paddr[2] == REG_GRID_SIZE)) begin
            r_grid <= pwdata[GRID_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_GRID_SIZE) ? APB_DATA_W'(r_grid) : '0;

    // Effective grid size: zero counts as one, and the size saturates at MAX_N.
    assign w_grid = EW'(r_grid);

    always_comb begin
        if (w_grid == '0) begin
            w_n = EW'(1);
        end else if (w_grid > EW'(MAX_N)) begin
            w_n = EW'(MAX_N);
        end else begin
            w_n = w_grid;
        end
    end

    // The value of the word at the input, and whether it closes the sweep.
    assign w_v    = r_vcnt + EW'(1);
    assign w_last = {1'b0, w_v} >= {w_n, 1'b0};

    // A closing word waits only while the result slot chain is still occupied.
    assign w_in_ready = !(r_busy && w_last);
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= '0;
        end else if (w_accept) begin
            r_vcnt <= w_last ? '0 : w_v;
        end
    end

    // Result transport: r_fly counts the cells still between the result and cell 0.
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_shift    = r_busy && (r_fly != '0);
    assign w_load     = r_busy && (r_fly == '0) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fly  <= '0;
        end else if (w_accept && w_last) begin
            r_busy <= 1'b1;
            r_fly  <= w_n;
        end else if (w_shift) begin
            r_fly  <= r_fly - EW'(1);
        end else if (w_load) begin
            r_busy <= 1'b0;
        end
    end

    // Output register. While a result waits here, the slot chain cannot empty and the next closing word waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_count <= w_out[0];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.path_count = r_out_count;

    // Control word broadcast to every cell.
    assign w_ctl.step      = w_accept;
    assign w_ctl.last_item = w_last;
    assign w_ctl.skip_l    = i_in.value_in_second_list;
    assign w_ctl.skip_r    = i_in.value_in_first_list;
    assign w_ctl.shift     = w_shift;

    // The chain of cells. Cell r holds the count at (v - r, r); its lower neighbor feeds
    // the r step, and its upper neighbor feeds the result slot when the chain shifts.
    for (genvar g = 0; g <= MAX_N; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = '0;
        end else begin : g_inner
            assign w_prev[g] = w_count[g-1];
        end

        if (g == MAX_N) begin : g_top
            assign w_next[g] = '0;
        end else begin : g_below
            assign w_next[g] = w_out[g+1];
        end

        cbpc_cell #(
            .IDX (g),
            .EW  (EW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_v          (w_v),
            .i_n          (w_n),
            .i_prev_count (w_prev[g]),
            .i_next_out   (w_next[g]),
            .o_count      (w_count[g]),
            .o_out        (w_out[g])
        );
    end

`ifndef NO_ASSERTIONS
    // The result leaves the slot chain only into the output register.
    a_busy_drains_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_out_valid)
        else $error("result chain emptied without loading the output register");

    // A result in flight never sits above the cell of index n.
    a_fly_within_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_fly <= w_n))
        else $error("result position beyond the grid size");

    // Every delivered count is a reduced residue.
    a_output_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count < COUNT_MOD))
        else $error("output count not reduced modulo the prime");

    // Reset leaves exactly one path at the origin.
    a_origin_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_count[0] == t_count'(1)))
        else $error("origin count is not one after reset");

    // A closing word resets the value counter for the next sweep.
    a_counter_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_vcnt == '0) && r_busy)
        else $error("sweep did not restart after its closing word");
`endif

endmodule

`default_nettype wire
